// ===== rtl/core/kplt_pkg.sv =====
`timescale 1ns / 1ps
package kplt_pkg;

  // default sizes
  localparam int MAX_HELD_DEF     = 16;
  localparam int LAYOUT_DEPTH_DEF = 32;
  localparam int MAX_RESULTS      = 16;
  localparam int RES_W            = $clog2(MAX_RESULTS + 1);

  // input operations
  localparam logic [1:0] OP_KEY   = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_ENTRY = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_START = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VLONG_PRESS = 3'd6;

  // configuration reset values
  localparam logic [CFG_W-1:0] FIRST_COUNT_RST  = 16'd30;
  localparam logic [CFG_W-1:0] REPEAT_START_RST = 16'd50;
  localparam logic [CFG_W-1:0] SLOW_PERIOD_RST  = 16'd10;
  localparam logic [CFG_W-1:0] FAST_START_RST   = 16'd200;
  localparam logic [CFG_W-1:0] FAST_PERIOD_RST  = 16'd2;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST   = 16'd0;
  localparam logic [CFG_W-1:0] VLONG_PRESS_RST  = 16'd0;

  // short codes that make an entry a counter
  localparam logic [9:0] COUNTER_CODE_X = 10'd1;
  localparam logic [9:0] COUNTER_CODE_Y = 10'd2;

  // held press flag bits
  localparam int FLAG_COUNT = 0;
  localparam int FLAG_LONG  = 1;
  localparam int FLAG_VLONG = 2;

  // remainder unit step count
  localparam int DIV_STEPS = 32;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         key_code;
    logic               pressed;
    logic [4:0]         entry_index;
    logic [9:0]         modifier_code;
    logic [9:0]         short_code;
    logic [9:0]         long_code;
    logic [9:0]         very_long_code;
    logic signed [31:0] count_amount;
  } in_beat_t;

  typedef struct packed {
    logic               event_kind;
    logic [9:0]         evt_code;
    logic signed [31:0] event_value;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] count_amount;
    logic [9:0]         very_long_code;
    logic [9:0]         long_code;
    logic [9:0]         short_code;
    logic [9:0]         modifier_code;
    logic [9:0]         key_code;
  } lay_word_t;

  typedef struct packed {
    logic done;
    logic zero;
  } mod_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PA_REQ,
    ST_PA_CHK,
    ST_PB_REQ,
    ST_PB_CHK,
    ST_RL_REQ,
    ST_RL_CHK,
    ST_RL_CAP,
    ST_RL_EMIT,
    ST_TK_REQ,
    ST_TK_CHK,
    ST_TK_CAP,
    ST_TK_EVAL,
    ST_TK_MOD,
    ST_TK_EMIT,
    ST_FIN
  } state_t;

  function automatic logic is_counter(input logic [9:0] code);
    return (code == COUNTER_CODE_X) || (code == COUNTER_CODE_Y);
  endfunction

  // event of an entry's short code
  function automatic out_beat_t ent_evt(input lay_word_t w);
    out_beat_t ev;
    ev.event_kind  = is_counter(w.short_code);
    ev.evt_code    = w.short_code;
    ev.event_value = ev.event_kind ? w.count_amount : 32'sd1;
    ev.last        = 1'b0;
    return ev;
  endfunction

endpackage

// ===== rtl/core/kplt_ram.sv =====
`timescale 1ns / 1ps
module kplt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/kplt_mod.sv =====
`timescale 1ns / 1ps
module kplt_mod import kplt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output mod_sts_t    sts
);

  logic [31:0] d_r;
  logic [15:0] p_r;
  logic [15:0] rem_r;
  logic [5:0]  cnt_r;
  logic        done_r;
  logic [16:0] trial;
  logic [16:0] diff;
  logic [15:0] rem_nxt;

  // one restoring remainder step per cycle while the step counter runs
  always_comb begin
    trial   = {rem_r, d_r[31]};
    diff    = trial - {1'b0, p_r};
    rem_nxt = (trial >= {1'b0, p_r}) ? diff[15:0] : trial[15:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= 6'(DIV_STEPS);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      d_r   <= dividend;
      p_r   <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      d_r   <= {d_r[30:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign sts.done = done_r;
  assign sts.zero = (rem_r == '0);

endmodule

// ===== rtl/core/keypad_layout_press_timer.sv =====
`timescale 1ns / 1ps
// steps: a press scans the layout in two table passes, read then check per entry;
//   a release reads then checks each held record, with capture and emit on a removed one
// a tick reads, checks, captures, evaluates and emits per held press, and waits where a
//   repeat count needs the serial remainder unit; the final beat is staged before the next item
// one item at a time, taken only in idle; layout and press memories have a single read port each
// reset: synchronous; clears control, counts, layout valid bits, loads config defaults
module keypad_layout_press_timer import kplt_pkg::*; #(
  parameter int MAX_HELD     = MAX_HELD_DEF,
  parameter int LAYOUT_DEPTH = LAYOUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_beat_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_beat_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int LW = (LAYOUT_DEPTH > 1) ? $clog2(LAYOUT_DEPTH) : 1;
  localparam int PW = (MAX_HELD > 1) ? $clog2(MAX_HELD) : 1;
  localparam int CW = $clog2(MAX_HELD + 1);

  typedef struct packed {
    logic [2:0]    flags;
    logic [31:0]   age;
    logic [LW-1:0] entry;
    logic [9:0]    key;
  } rec_t;

  state_t state_r, state_nxt;

  in_beat_t  item_r;
  logic [CFG_W-1:0] first_r, rstart_r, slow_r, fstart_r, fast_r, long_r, vlong_r;

  logic [LAYOUT_DEPTH-1:0] lay_vld_r;
  logic                    lay_vld_q_r;
  logic                    lay_we;
  logic [LW-1:0]           lay_waddr, lay_raddr;
  lay_word_t               lay_wdata, lay_raw, lay_q;

  logic          pr_we;
  logic [PW-1:0] pr_waddr, pr_raddr;
  rec_t          pr_wdata, pr_q;
  logic [$bits(rec_t)-1:0] pr_raw;

  logic [9:0]    down_set_r [MAX_HELD];
  logic [CW-1:0] down_total_r, press_total_r;
  logic [CW-1:0] dlast, pr_last;

  logic [LW-1:0]    e_r;
  logic [CW-1:0]    i_r;
  logic             modified_r;
  rec_t             rec_r;
  lay_word_t        tgt_r;
  logic             due_r;
  out_beat_t        evt_r;
  logic [RES_W-1:0] n_r;

  out_beat_t pend_r, out_r, fin_beat;
  logic      pend_vld_r, out_vld_r;

  logic accept, out_free, emit_req, emit_go, emit_done, fin_go;
  logic code_down, mod_down, rm_hit;
  logic [PW-1:0] rm_idx;
  logic lay_end, e_last, match, fire, list_done, key_match;
  logic ins_down, rm_down, pb_fire, tk_wb;

  logic        mod_start, need_mod, due_now, vl_hit, l_hit, ctr;
  logic [31:0] t, mod_dividend;
  logic [15:0] mod_divisor;
  mod_sts_t    mod_sts;

  // layout table and held press list
  kplt_ram #(.WIDTH($bits(lay_word_t)), .DEPTH(LAYOUT_DEPTH)) u_lay_ram (
    .clk(clk), .we(lay_we), .waddr(lay_waddr), .wdata(lay_wdata),
    .raddr(lay_raddr), .rdata(lay_raw)
  );

  kplt_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_HELD)) u_press_ram (
    .clk(clk), .we(pr_we), .waddr(pr_waddr), .wdata(pr_wdata),
    .raddr(pr_raddr), .rdata(pr_raw)
  );

  kplt_mod u_mod (
    .clk(clk), .rst_n(rst_n), .start(mod_start),
    .dividend(mod_dividend), .divisor(mod_divisor), .sts(mod_sts)
  );

  assign pr_q  = rec_t'(pr_raw);
  // an entry never written reads as zero, which ends a scan
  assign lay_q = lay_vld_q_r ? lay_raw : '0;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign dlast   = down_total_r - CW'(1);
  assign pr_last = press_total_r - CW'(1);

  // down set lookups over all lanes
  always_comb begin
    code_down = 1'b0;
    mod_down  = 1'b0;
    rm_hit    = 1'b0;
    rm_idx    = '0;
    for (int k = MAX_HELD - 1; k >= 0; k--) begin
      if (CW'(k) < down_total_r) begin
        if (down_set_r[k] == in_data.key_code) code_down = 1'b1;
        if (down_set_r[k] == lay_q.modifier_code) mod_down = 1'b1;
        if (down_set_r[k] == item_r.key_code) begin
          rm_hit = 1'b1;
          rm_idx = PW'(k);
        end
      end
    end
  end

  // scan conditions
  assign lay_end   = (lay_q.key_code == '0);
  assign e_last    = (e_r == LW'(LAYOUT_DEPTH - 1));
  assign match     = (lay_q.key_code == item_r.key_code);
  assign fire      = match && (modified_r ? (lay_q.modifier_code != '0 && mod_down)
                                          : (lay_q.modifier_code == '0));
  assign list_done = (i_r >= press_total_r);
  assign key_match = (pr_q.key == item_r.key_code);

  // result staging: one pending beat so the final one can carry last
  assign out_free  = !out_vld_r || out_ready;
  assign emit_req  = (state_r == ST_RL_EMIT || state_r == ST_TK_EMIT) && due_r;
  assign emit_go   = emit_req && (n_r < RES_W'(MAX_RESULTS)) && (!pend_vld_r || out_free);
  assign emit_done = emit_req && ((n_r >= RES_W'(MAX_RESULTS)) || !pend_vld_r || out_free);
  assign fin_go    = (state_r == ST_FIN) && (!pend_vld_r || out_free);

  // pending beat marked as the final one of its item
  always_comb begin
    fin_beat      = pend_r;
    fin_beat.last = 1'b1;
  end

  assign ins_down = accept && in_data.op == OP_KEY && in_data.pressed && !code_down &&
                    down_total_r < CW'(MAX_HELD);
  assign rm_down  = (state_r == ST_RL_REQ) && list_done && rm_hit;
  assign pb_fire  = (state_r == ST_PB_CHK) && !lay_end && fire &&
                    press_total_r < CW'(MAX_HELD);
  assign tk_wb    = (state_r == ST_TK_EMIT) && (!due_r || emit_done);

  // tick timing decision on the aged record
  always_comb begin
    t            = rec_r.age;
    ctr          = is_counter(tgt_r.short_code);
    need_mod     = 1'b0;
    due_now      = 1'b0;
    mod_dividend = '0;
    mod_divisor  = 16'd1;
    if (t < {16'd0, first_r}) begin
      due_now = 1'b0;
    end else if (t == {16'd0, first_r}) begin
      due_now = 1'b1;
    end else if (t >= {16'd0, rstart_r}) begin
      need_mod = ctr;
      if (t < {16'd0, fstart_r}) begin
        mod_dividend = t - {16'd0, rstart_r};
        mod_divisor  = (slow_r == '0) ? 16'd1 : slow_r;
      end else begin
        mod_dividend = t - {16'd0, fstart_r};
        mod_divisor  = (fast_r == '0) ? 16'd1 : fast_r;
      end
    end
    vl_hit = tgt_r.very_long_code != '0 && vlong_r != '0 && !rec_r.flags[FLAG_VLONG] &&
             t >= {16'd0, vlong_r};
    l_hit  = tgt_r.long_code != '0 && long_r != '0 && !rec_r.flags[FLAG_LONG] &&
             t >= {16'd0, long_r};
  end

  assign mod_start = (state_r == ST_TK_EVAL) && need_mod;

  // memory addresses and writes
  always_comb begin
    lay_we    = accept && in_data.op == OP_ENTRY &&
                int'(in_data.entry_index) < LAYOUT_DEPTH;
    lay_waddr = LW'(in_data.entry_index);
    lay_wdata.count_amount   = in_data.count_amount;
    lay_wdata.very_long_code = in_data.very_long_code;
    lay_wdata.long_code      = in_data.long_code;
    lay_wdata.short_code     = in_data.short_code;
    lay_wdata.modifier_code  = in_data.modifier_code;
    lay_wdata.key_code       = in_data.key_code;
    lay_raddr = (state_r == ST_RL_CHK || state_r == ST_TK_CHK) ? pr_q.entry : e_r;

    pr_raddr = (state_r == ST_RL_CHK) ? pr_last[PW-1:0] : i_r[PW-1:0];
    pr_we    = pb_fire || (state_r == ST_RL_CAP) || tk_wb;
    pr_waddr = i_r[PW-1:0];
    pr_wdata = rec_r;
    if (pb_fire) begin
      pr_waddr       = press_total_r[PW-1:0];
      pr_wdata.flags = '0;
      pr_wdata.age   = '0;
      pr_wdata.entry = e_r;
      pr_wdata.key   = item_r.key_code;
    end else if (state_r == ST_RL_CAP) begin
      // swap the last record into the released slot
      pr_wdata = pr_q;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_KEY:  state_nxt = in_data.pressed ? ST_PA_REQ : ST_RL_REQ;
            OP_TICK: state_nxt = ST_TK_REQ;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_PA_REQ:  state_nxt = ST_PA_CHK;
      ST_PA_CHK:  state_nxt = (lay_end || e_last) ? ST_PB_REQ : ST_PA_REQ;
      ST_PB_REQ:  state_nxt = ST_PB_CHK;
      ST_PB_CHK:  state_nxt = (lay_end || e_last) ? ST_FIN : ST_PB_REQ;
      ST_RL_REQ:  state_nxt = list_done ? ST_FIN : ST_RL_CHK;
      ST_RL_CHK:  state_nxt = key_match ? ST_RL_CAP : ST_RL_REQ;
      ST_RL_CAP:  state_nxt = ST_RL_EMIT;
      ST_RL_EMIT: begin
        if (!due_r || emit_done) state_nxt = ST_RL_REQ;
      end
      ST_TK_REQ:  state_nxt = list_done ? ST_FIN : ST_TK_CHK;
      ST_TK_CHK:  state_nxt = ST_TK_CAP;
      ST_TK_CAP:  state_nxt = ST_TK_EVAL;
      ST_TK_EVAL: state_nxt = need_mod ? ST_TK_MOD : ST_TK_EMIT;
      ST_TK_MOD: begin
        if (mod_sts.done) state_nxt = ST_TK_EMIT;
      end
      ST_TK_EMIT: begin
        if (tk_wb) state_nxt = ST_TK_REQ;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state, counts, config and output staging
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      down_total_r  <= '0;
      press_total_r <= '0;
      lay_vld_r     <= '0;
      pend_vld_r    <= 1'b0;
      out_vld_r     <= 1'b0;
      n_r           <= '0;
      first_r       <= FIRST_COUNT_RST;
      rstart_r      <= REPEAT_START_RST;
      slow_r        <= SLOW_PERIOD_RST;
      fstart_r      <= FAST_START_RST;
      fast_r        <= FAST_PERIOD_RST;
      long_r        <= LONG_PRESS_RST;
      vlong_r       <= VLONG_PRESS_RST;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_index)
          CFG_FIRST_COUNT:  first_r  <= cfg_wdata;
          CFG_REPEAT_START: rstart_r <= cfg_wdata;
          CFG_SLOW_PERIOD:  slow_r   <= cfg_wdata;
          CFG_FAST_START:   fstart_r <= cfg_wdata;
          CFG_FAST_PERIOD:  fast_r   <= cfg_wdata;
          CFG_LONG_PRESS:   long_r   <= cfg_wdata;
          CFG_VLONG_PRESS:  vlong_r  <= cfg_wdata;
          default: ;
        endcase
      end

      if (lay_we) lay_vld_r[lay_waddr] <= 1'b1;

      if (ins_down) down_total_r <= down_total_r + CW'(1);
      else if (rm_down) down_total_r <= dlast;

      if (pb_fire) press_total_r <= press_total_r + CW'(1);
      else if (state_r == ST_RL_CAP) press_total_r <= pr_last;

      if (accept) n_r <= '0;
      else if (emit_go) n_r <= n_r + RES_W'(1);

      // move the pending beat out when a newer one arrives or the item ends
      if (emit_go && pend_vld_r) begin
        out_r      <= pend_r;
        out_vld_r  <= 1'b1;
      end else if (fin_go && pend_vld_r) begin
        out_r      <= fin_beat;
        out_vld_r  <= 1'b1;
      end else if (out_ready) begin
        out_vld_r  <= 1'b0;
      end

      if (emit_go) begin
        pend_r     <= evt_r;
        pend_vld_r <= 1'b1;
      end else if (fin_go) begin
        pend_vld_r <= 1'b0;
      end
    end
  end

  // item data, scan pointers and working record
  always_ff @(posedge clk) begin
    lay_vld_q_r <= lay_vld_r[lay_raddr];
    if (ins_down) down_set_r[down_total_r[PW-1:0]] <= in_data.key_code;
    if (rm_down) down_set_r[rm_idx] <= down_set_r[dlast[PW-1:0]];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_r     <= in_data;
          e_r        <= '0;
          i_r        <= '0;
          modified_r <= 1'b0;
        end
      end
      ST_PA_CHK: begin
        if (!lay_end && match && lay_q.modifier_code != '0 && mod_down) modified_r <= 1'b1;
        e_r <= (lay_end || e_last) ? '0 : e_r + LW'(1);
      end
      ST_PB_CHK: e_r <= e_r + LW'(1);
      ST_RL_CHK: begin
        rec_r <= pr_q;
        if (!key_match) i_r <= i_r + CW'(1);
      end
      ST_RL_CAP: begin
        evt_r <= ent_evt(lay_q);
        due_r <= is_counter(lay_q.short_code) ? !rec_r.flags[FLAG_COUNT]
               : !(rec_r.flags[FLAG_LONG] || rec_r.flags[FLAG_VLONG]);
      end
      ST_TK_CHK: rec_r <= pr_q;
      ST_TK_CAP: begin
        tgt_r <= lay_q;
        evt_r <= ent_evt(lay_q);
        if (rec_r.age != '1) rec_r.age <= rec_r.age + 32'd1;
      end
      ST_TK_EVAL: begin
        if (ctr) begin
          due_r <= due_now;
          if (due_now) rec_r.flags[FLAG_COUNT] <= 1'b1;
        end else if (vl_hit) begin
          due_r <= 1'b1;
          evt_r.event_kind  <= 1'b0;
          evt_r.evt_code    <= tgt_r.very_long_code;
          evt_r.event_value <= 32'sd1;
          rec_r.flags[FLAG_VLONG] <= 1'b1;
          rec_r.flags[FLAG_LONG]  <= 1'b1;
        end else if (l_hit) begin
          due_r <= 1'b1;
          evt_r.event_kind  <= 1'b0;
          evt_r.evt_code    <= tgt_r.long_code;
          evt_r.event_value <= 32'sd1;
          rec_r.flags[FLAG_LONG] <= 1'b1;
        end else begin
          due_r <= 1'b0;
        end
      end
      ST_TK_MOD: begin
        if (mod_sts.done) begin
          due_r <= mod_sts.zero;
          if (mod_sts.zero) rec_r.flags[FLAG_COUNT] <= 1'b1;
        end
      end
      ST_TK_EMIT: begin
        if (tk_wb) i_r <= i_r + CW'(1);
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // list counts never pass their capacity
  a_press_cap: assert property (@(posedge clk) disable iff (!rst_n)
    press_total_r <= CW'(MAX_HELD)) else $error("press list overflow");

  a_down_cap: assert property (@(posedge clk) disable iff (!rst_n)
    down_total_r <= CW'(MAX_HELD)) else $error("down set overflow");

  // an item ends only after its pending beat has gone out
  a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_vld_r) else $error("pending beat left at idle");

  // per item result budget
  a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= RES_W'(MAX_RESULTS)) else $error("too many results");

  // the remainder unit starts only from the evaluate step of a tick
  a_mod_start: assert property (@(posedge clk) disable iff (!rst_n)
    mod_start |=> state_r == ST_TK_MOD) else $error("remainder start out of place");
`endif

endmodule
